>>> rtl/weighted_aging_job_scheduler_top_assert.svh
// Assertion macros used by the job scheduler controller, wajs_ctrl.
// Define NO_ASSERTIONS to compile the macros to nothing.
`ifndef WEIGHTED_AGING_JOB_SCHEDULER_TOP_ASSERT_SVH
`define WEIGHTED_AGING_JOB_SCHEDULER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Check a property on each rising edge, off while reset is asserted
`define WAJS_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on each rising edge, reset included
`define WAJS_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define WAJS_ASSERT(label, clk, rst_n, prop, msg)
`define WAJS_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

>>> rtl/wajs_pkg.sv
// Package for the weighted aging job scheduler: widths, request and status
// codes, and the command/status structs between controller and datapath.
`timescale 1ns / 1ps

package wajs_pkg;

	// Table geometry
	localparam int MAX_JOBS    = 16;
	localparam int CREDIT_BITS = 16;
	localparam int IDX_W       = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
	localparam int CNT_W       = $clog2(MAX_JOBS + 1);

	// Field widths
	localparam int REQ_W    = 3;
	localparam int ID_W     = 4;
	localparam int CLASS_W  = 6;
	localparam int CAPS_W   = 64;
	localparam int WEIGHT_W = 8;
	localparam int PRIO_W   = 8;
	localparam int STATUS_W = 2;
	localparam int PROD_W   = CREDIT_BITS + WEIGHT_W;

	localparam logic [CREDIT_BITS-1:0] CREDIT_MAX = '1;
	localparam logic [PRIO_W-1:0]      PRIO_RESET = PRIO_W'(1);

	typedef enum logic [REQ_W-1:0] {
		REQ_ADD    = 3'd0,
		REQ_REMOVE = 3'd1,
		REQ_SELECT = 3'd2,
		REQ_UPDATE = 3'd3,
		REQ_LOOKUP = 3'd4,
		REQ_CLEAR  = 3'd5
	} req_code_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK        = 2'd0,
		STS_FULL      = 2'd1,
		STS_NOT_FOUND = 2'd2,
		STS_NO_JOB    = 2'd3
	} status_code_t;

	// Controller to datapath
	typedef struct packed {
		logic load;     // latch the incoming request
		logic scan_en;  // age and compare one table entry
		logic commit;   // apply the request and load the result register
	} wajs_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic req_is_select;  // incoming request is a select
		logic scan_last;      // scan is at the last entry
		logic out_free;       // result register can take a new result
	} wajs_stat_t;

endpackage

>>> rtl/wajs_if.sv
// Request and result channel interfaces of the job scheduler.
// Depends on wajs_pkg for field widths.
`timescale 1ns / 1ps

interface wajs_req_if;
	import wajs_pkg::*;

	logic                valid;
	logic                ready;
	logic [REQ_W-1:0]    req_type;
	logic [ID_W-1:0]     job_id;
	logic [CLASS_W-1:0]  job_class;
	logic [CAPS_W-1:0]   capabilities;
	logic                set_active;
	logic [WEIGHT_W-1:0] set_weight;

	modport source (
		output valid, req_type, job_id, job_class, capabilities, set_active, set_weight,
		input  ready
	);
	modport sink (
		input  valid, req_type, job_id, job_class, capabilities, set_active, set_weight,
		output ready
	);
endinterface

interface wajs_rsp_if;
	import wajs_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [ID_W-1:0]     result_id;
	logic                found;

	modport source (
		output valid, status, result_id, found,
		input  ready
	);
	modport sink (
		input  valid, status, result_id, found,
		output ready
	);
endinterface

>>> rtl/wajs_ctrl.sv
// Controller of the job scheduler: sequences accept, table scan and commit.
// Depends on wajs_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "weighted_aging_job_scheduler_top_assert.svh"

module wajs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  wajs_pkg::wajs_stat_t stat,
	output wajs_pkg::wajs_cmd_t  cmd
);
	import wajs_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t state_q;
	state_t state_nx;
	logic   load;

	// Take a request only when no request is in flight
	assign req_ready = (state_q == S_IDLE);
	assign load      = req_valid && req_ready;

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (load) begin
					state_nx = stat.req_is_select ? S_SCAN : S_DONE;
				end
			end
			S_SCAN: begin
				if (stat.scan_last) begin
					state_nx = S_DONE;
				end
			end
			S_DONE: begin
				if (stat.out_free) begin
					state_nx = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Drive datapath commands
	always_comb begin
		cmd.load    = load;
		cmd.scan_en = (state_q == S_SCAN);
		cmd.commit  = (state_q == S_DONE) && stat.out_free;
	end

	`WAJS_ASSERT(a_load_starts_work, clk, arst_n, load |=> (state_q == S_SCAN || state_q == S_DONE), "accepted request did not start")
	`WAJS_ASSERT(a_scan_ends_done, clk, arst_n, (state_q == S_SCAN && stat.scan_last) |=> (state_q == S_DONE), "scan did not end in commit state")
	`WAJS_ASSERT_ALWAYS(a_commit_free, clk, cmd.commit |-> stat.out_free, "result overwritten before taken")
	`WAJS_ASSERT(a_commit_idle, clk, arst_n, cmd.commit |=> (state_q == S_IDLE), "commit did not return to idle")

endmodule

>>> rtl/wajs_dp.sv
// Datapath of the job scheduler: job table, select scan, result register.
// Depends on wajs_pkg; driven by wajs_ctrl commands.
`timescale 1ns / 1ps

module wajs_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [wajs_pkg::PRIO_W-1:0]       cfg_wdata,
	input  logic [wajs_pkg::REQ_W-1:0]        req_type,
	input  logic [wajs_pkg::ID_W-1:0]         job_id,
	input  logic [wajs_pkg::CLASS_W-1:0]      job_class,
	input  logic [wajs_pkg::CAPS_W-1:0]       capabilities,
	input  logic                              set_active,
	input  logic [wajs_pkg::WEIGHT_W-1:0]     set_weight,
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	output logic [wajs_pkg::STATUS_W-1:0]     rsp_status,
	output logic [wajs_pkg::ID_W-1:0]         rsp_result_id,
	output logic                              rsp_found,
	input  wajs_pkg::wajs_cmd_t               cmd,
	output wajs_pkg::wajs_stat_t              stat
);
	import wajs_pkg::*;

	// Latched request
	logic [REQ_W-1:0]    req_type_q;
	logic [ID_W-1:0]     job_id_q;
	logic [CLASS_W-1:0]  job_class_q;
	logic [CAPS_W-1:0]   caps_q;
	logic                set_active_q;
	logic [WEIGHT_W-1:0] set_weight_q;
	logic [PRIO_W-1:0]   init_prio_q;

	// Job table
	logic [MAX_JOBS-1:0]    valid_q;
	logic [MAX_JOBS-1:0]    active_q;
	logic [CLASS_W-1:0]     class_q  [MAX_JOBS];
	logic [WEIGHT_W-1:0]    weight_q [MAX_JOBS];
	logic [CREDIT_BITS-1:0] credit_q [MAX_JOBS];

	// Scan state
	logic [IDX_W-1:0]       scan_idx_q;
	logic [CNT_W-1:0]       count_q;
	logic                   best_found_q;
	logic [IDX_W-1:0]       best_id_q;
	logic [PROD_W-1:0]      best_val_q;
	logic [CREDIT_BITS-1:0] best_credit_q;

	// Result register
	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [ID_W-1:0]     out_rid_q;
	logic                out_found_q;

	logic                   elig;
	logic [CREDIT_BITS-1:0] aged;
	logic [PROD_W-1:0]      prod;
	logic                   better;

	logic                   id_in_range;
	logic [IDX_W-1:0]       id_idx;
	logic                   hit;
	logic                   free_found;
	logic [IDX_W-1:0]       free_idx;
	logic [CREDIT_BITS-1:0] cnt_ext;
	logic [CREDIT_BITS-1:0] win_credit;

	logic [STATUS_W-1:0] nx_status;
	logic [ID_W-1:0]     nx_rid;
	logic                nx_found;
	logic                do_add;
	logic                do_remove;
	logic                do_update;
	logic                do_clear;
	logic                do_win;

	// Status toward the controller
	always_comb begin
		stat.req_is_select = (req_type == REQ_SELECT);
		stat.scan_last     = (scan_idx_q == IDX_W'(MAX_JOBS - 1));
		stat.out_free      = !out_valid_q || rsp_ready;
	end

	// Hold the configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_prio_q <= PRIO_RESET;
		end else if (cfg_we) begin
			init_prio_q <= cfg_wdata;
		end
	end

	// Latch the request payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_type_q   <= req_type;
			job_id_q     <= job_id;
			job_class_q  <= job_class;
			caps_q       <= capabilities;
			set_active_q <= set_active;
			set_weight_q <= set_weight;
		end
	end

	// Age the entry under scan and score it
	always_comb begin
		elig   = valid_q[scan_idx_q] && active_q[scan_idx_q] && caps_q[class_q[scan_idx_q]];
		aged   = (credit_q[scan_idx_q] == CREDIT_MAX) ? credit_q[scan_idx_q]
			: credit_q[scan_idx_q] + CREDIT_BITS'(1);
		prod   = PROD_W'(aged) * PROD_W'(weight_q[scan_idx_q]);
		better = elig && (!best_found_q || (prod > best_val_q));
	end

	// Advance the scan and track the best entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q   <= '0;
			count_q      <= '0;
			best_found_q <= 1'b0;
		end else if (cmd.load) begin
			scan_idx_q   <= '0;
			count_q      <= '0;
			best_found_q <= 1'b0;
		end else if (cmd.scan_en) begin
			scan_idx_q <= scan_idx_q + IDX_W'(1);
			if (elig) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (better) begin
				best_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_en && better) begin
			best_id_q     <= scan_idx_q;
			best_val_q    <= prod;
			best_credit_q <= aged;
		end
	end

	// Decode the request against the table
	always_comb begin
		id_in_range = (32'(job_id_q) < MAX_JOBS);
		id_idx      = IDX_W'(job_id_q);
		hit         = id_in_range && valid_q[id_idx];

		free_found = 1'b0;
		free_idx   = '0;
		for (int i = MAX_JOBS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(i);
			end
		end

		cnt_ext    = CREDIT_BITS'(count_q);
		win_credit = (best_credit_q > cnt_ext) ? (best_credit_q - cnt_ext) : '0;

		nx_status = STS_OK;
		nx_rid    = '0;
		nx_found  = 1'b0;
		do_add    = 1'b0;
		do_remove = 1'b0;
		do_update = 1'b0;
		do_clear  = 1'b0;
		do_win    = 1'b0;
		case (req_type_q)
			REQ_ADD: begin
				if (free_found) begin
					do_add = 1'b1;
					nx_rid = ID_W'(free_idx);
				end else begin
					nx_status = STS_FULL;
				end
			end
			REQ_REMOVE: begin
				if (hit) begin
					do_remove = 1'b1;
					nx_found  = 1'b1;
				end else begin
					nx_status = STS_NOT_FOUND;
				end
			end
			REQ_SELECT: begin
				if (best_found_q) begin
					do_win = 1'b1;
					nx_rid = ID_W'(best_id_q);
				end else begin
					nx_status = STS_NO_JOB;
				end
			end
			REQ_UPDATE: begin
				if (hit) begin
					do_update = 1'b1;
				end else begin
					nx_status = STS_NOT_FOUND;
				end
			end
			REQ_LOOKUP: begin
				if (hit) begin
					nx_found = 1'b1;
				end else begin
					nx_status = STS_NOT_FOUND;
				end
			end
			REQ_CLEAR: begin
				do_clear = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Update the valid and active flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			active_q <= '0;
		end else if (cmd.commit) begin
			if (do_clear) begin
				valid_q  <= '0;
				active_q <= '0;
			end
			if (do_add) begin
				valid_q[free_idx]  <= 1'b1;
				active_q[free_idx] <= 1'b0;
			end
			if (do_remove) begin
				valid_q[id_idx]  <= 1'b0;
				active_q[id_idx] <= 1'b0;
			end
			if (do_update) begin
				active_q[id_idx] <= set_active_q;
			end
		end
	end

	// Write class, weight and credit
	always_ff @(posedge clk) begin
		if (cmd.scan_en && elig) begin
			credit_q[scan_idx_q] <= aged;
		end
		if (cmd.commit) begin
			if (do_add) begin
				class_q[free_idx]  <= job_class_q;
				weight_q[free_idx] <= WEIGHT_W'(init_prio_q);
				credit_q[free_idx] <= CREDIT_BITS'(init_prio_q);
			end
			if (do_update) begin
				weight_q[id_idx] <= set_weight_q;
			end
			if (do_win) begin
				credit_q[best_id_q] <= win_credit;
			end
		end
	end

	// Hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_status_q <= nx_status;
			out_rid_q    <= nx_rid;
			out_found_q  <= nx_found;
		end
	end

	assign rsp_valid     = out_valid_q;
	assign rsp_status    = out_status_q;
	assign rsp_result_id = out_rid_q;
	assign rsp_found     = out_found_q;

endmodule

>>> rtl/weighted_aging_job_scheduler_top.sv
// Weighted aging job scheduler: a table of up to MAX_JOBS jobs, one result
// per request.
//
// Channels: req_ch carries one request (add, remove, select, update, lookup,
// clear all) per valid/ready handshake; rsp_ch returns status, result_id and
// found for it. cfg_we/cfg_wdata write initial_priority; write it only while
// no request is in flight.
// Select passes from accept through a scan of the whole table to the
// commit; the table is aged and scored one entry per cycle
// through a single multiplier. Every other request goes from accept
// straight to the commit. One request is in flight at a time, so a new
// request is taken only once the previous one has committed.
// A result sits in an output register; while the receiver stalls, the
// block may take the next request and works it up to its commit, then
// waits until the held result is taken.
// Reset empties the table and sets initial_priority to 1; no clearing
// pass is needed.
// Depends on wajs_pkg, wajs_if, wajs_ctrl and wajs_dp.
`timescale 1ns / 1ps

module weighted_aging_job_scheduler_top (
	input  logic                        clk,
	input  logic                        arst_n,
	wajs_req_if.sink                    req_ch,
	wajs_rsp_if.source                  rsp_ch,
	input  logic                        cfg_we,
	input  logic [wajs_pkg::PRIO_W-1:0] cfg_wdata
);
	import wajs_pkg::*;

	wajs_cmd_t  cmd;
	wajs_stat_t stat;

	// Sequence requests
	wajs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_ch.valid),
		.req_ready (req_ch.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Table, scan and result register
	wajs_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.req_type      (req_ch.req_type),
		.job_id        (req_ch.job_id),
		.job_class     (req_ch.job_class),
		.capabilities  (req_ch.capabilities),
		.set_active    (req_ch.set_active),
		.set_weight    (req_ch.set_weight),
		.rsp_valid     (rsp_ch.valid),
		.rsp_ready     (rsp_ch.ready),
		.rsp_status    (rsp_ch.status),
		.rsp_result_id (rsp_ch.result_id),
		.rsp_found     (rsp_ch.found),
		.cmd           (cmd),
		.stat          (stat)
	);

endmodule

>>> bench/wajs_checker.sv
// Checker for the weighted aging job scheduler: watches the request, result
// and priority-write ports, predicts each result and compares it.
// Depends on wajs_pkg and the channel interfaces in wajs_if.
`timescale 1ns / 1ps

module wajs_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	wajs_req_if                         req_mon,
	wajs_rsp_if                         rsp_mon,
	input  logic                        cfg_we,
	input  logic [wajs_pkg::PRIO_W-1:0] cfg_wdata,
	output int                          fail_count,
	output int                          pending,
	output int                          checked,
	output int                          wins,
	output int                          fulls
);
	import wajs_pkg::*;

	localparam longint SELECT_FLOOR = -100000;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ID_W-1:0]     result_id;
		logic                found;
	} outcome_t;

	// Shadow job table and priority register
	logic                   job_valid   [MAX_JOBS];
	logic                   job_enabled [MAX_JOBS];
	logic [CLASS_W-1:0]     job_class   [MAX_JOBS];
	logic [WEIGHT_W-1:0]    job_weight  [MAX_JOBS];
	logic [CREDIT_BITS-1:0] job_credit  [MAX_JOBS];
	logic [PRIO_W-1:0]      init_prio;

	outcome_t expected_q [$];

	// Apply one request to the shadow table and return its result
	function automatic outcome_t schedule_request(
		input logic [REQ_W-1:0]    rt,
		input logic [ID_W-1:0]     id,
		input logic [CLASS_W-1:0]  cls,
		input logic [CAPS_W-1:0]   caps,
		input logic                act,
		input logic [WEIGHT_W-1:0] wgt
	);
		outcome_t o;
		int       i;
		int       slot;
		int       best;
		int       eligible;
		longint   best_score;
		longint   score;
		logic     hit;

		o    = '0;
		hit  = (int'(id) < MAX_JOBS) && job_valid[id];
		case (rt)
			REQ_ADD: begin
				slot = -1;
				for (i = 0; i < MAX_JOBS && slot < 0; i++)
					if (!job_valid[i])
						slot = i;
				if (slot < 0) begin
					o.status = STS_FULL;
				end else begin
					job_valid[slot]   = 1'b1;
					job_enabled[slot] = 1'b0;
					job_class[slot]   = cls;
					job_weight[slot]  = init_prio;
					job_credit[slot]  = CREDIT_BITS'(init_prio);
					o.result_id       = ID_W'(slot);
				end
			end
			REQ_REMOVE: begin
				if (hit) begin
					job_valid[id]   = 1'b0;
					job_enabled[id] = 1'b0;
					o.found         = 1'b1;
				end else begin
					o.status = STS_NOT_FOUND;
				end
			end
			REQ_SELECT: begin
				best       = -1;
				best_score = SELECT_FLOOR;
				eligible   = 0;
				// Age every eligible job, keep the first highest score
				for (i = 0; i < MAX_JOBS; i++) begin
					if (job_valid[i] && job_enabled[i] && caps[job_class[i]]) begin
						if (job_credit[i] != CREDIT_MAX)
							job_credit[i] = job_credit[i] + CREDIT_BITS'(1);
						eligible++;
						score = longint'(job_credit[i]) * longint'(job_weight[i]);
						if (score > best_score) begin
							best_score = score;
							best       = i;
						end
					end
				end
				if (best < 0) begin
					o.status = STS_NO_JOB;
				end else begin
					// Charge the winner, floor at zero
					if (int'(job_credit[best]) > eligible)
						job_credit[best] = job_credit[best] - CREDIT_BITS'(eligible);
					else
						job_credit[best] = '0;
					o.result_id = ID_W'(best);
				end
			end
			REQ_UPDATE: begin
				if (hit) begin
					job_enabled[id] = act;
					job_weight[id]  = wgt;
				end else begin
					o.status = STS_NOT_FOUND;
				end
			end
			REQ_LOOKUP: begin
				if (hit)
					o.found = 1'b1;
				else
					o.status = STS_NOT_FOUND;
			end
			REQ_CLEAR: begin
				for (i = 0; i < MAX_JOBS; i++) begin
					job_valid[i]   = 1'b0;
					job_enabled[i] = 1'b0;
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	task automatic report_field(input string name, input int exp_val, input int act_val);
		if (exp_val != act_val) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_val, act_val);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		outcome_t exp_o;
		if (!arst_n) begin
			for (int i = 0; i < MAX_JOBS; i++) begin
				job_valid[i]   = 1'b0;
				job_enabled[i] = 1'b0;
				job_class[i]   = '0;
				job_weight[i]  = '0;
				job_credit[i]  = '0;
			end
			init_prio = PRIO_RESET;
			expected_q.delete();
			fail_count = 0;
			checked    = 0;
			wins       = 0;
			fulls      = 0;
		end else begin
			// Compare each accepted result with the oldest prediction
			if (rsp_mon.valid && rsp_mon.ready) begin
				if (expected_q.size() == 0) begin
					$display("%0t: result with no request outstanding, status %0d id %0d found %0d",
						$time, rsp_mon.status, rsp_mon.result_id, rsp_mon.found);
					fail_count++;
				end else begin
					exp_o = expected_q.pop_front();
					report_field("status", int'(exp_o.status), int'(rsp_mon.status));
					report_field("result_id", int'(exp_o.result_id), int'(rsp_mon.result_id));
					report_field("found", int'(exp_o.found), int'(rsp_mon.found));
					checked++;
				end
			end
			// Track the priority register
			if (cfg_we)
				init_prio = cfg_wdata;
			// Predict each accepted request
			if (req_mon.valid && req_mon.ready) begin
				exp_o = schedule_request(req_mon.req_type, req_mon.job_id, req_mon.job_class,
					req_mon.capabilities, req_mon.set_active, req_mon.set_weight);
				if (req_mon.req_type == REQ_SELECT && exp_o.status == STS_OK)
					wins++;
				if (exp_o.status == STS_FULL)
					fulls++;
				expected_q.push_back(exp_o);
			end
		end
		pending = expected_q.size();
	end

endmodule

>>> bench/tb_top.sv
// Testbench top for the weighted aging job scheduler: clock, reset, request
// and result traffic, priority writes and the verdict.
// Depends on wajs_pkg, wajs_if, the scheduler RTL and wajs_checker.
`timescale 1ns / 1ps

module tb_top;
	import wajs_pkg::*;

	localparam logic [REQ_W-1:0]  REQ_SPARE_6     = 3'd6;
	localparam logic [REQ_W-1:0]  REQ_SPARE_7     = 3'd7;
	localparam logic [CAPS_W-1:0] CAPS_ALL        = '1;
	localparam logic [CAPS_W-1:0] CAPS_NONE       = '0;
	localparam logic [CAPS_W-1:0] CAPS_TOP_CLASS  = {1'b1, {(CAPS_W-1){1'b0}}};
	localparam int                HOLD_OFF_CYCLES = 80;
	localparam int                PHASES          = 6;
	localparam int                PHASE_ITEMS     = 305;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [PRIO_W-1:0] cfg_wdata;
	logic              gaps_on;

	int fail_count;
	int pending;
	int checked;
	int wins;
	int fulls;

	wajs_req_if req_ch ();
	wajs_rsp_if rsp_ch ();

	weighted_aging_job_scheduler_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_ch    (req_ch),
		.rsp_ch    (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	wajs_checker sched_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_mon    (req_ch),
		.rsp_mon    (rsp_ch),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked),
		.wins       (wins),
		.fulls      (fulls)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard stop for a hung run
	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

	// Result side: random ready gaps, two long hold-offs to back up requests
	initial begin
		int gap;
		int taken;
		rsp_ch.ready = 1'b0;
		taken        = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			gap = gaps_on ? $urandom_range(0, 3) : 0;
			if (taken == 120 || taken == 1000)
				gap = HOLD_OFF_CYCLES;
			if (gap > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
			taken++;
		end
	end

	// Offer one request after a random gap, hold it until accepted
	task automatic send_request(
		input logic [REQ_W-1:0]    rt,
		input logic [ID_W-1:0]     id,
		input logic [CLASS_W-1:0]  cls,
		input logic [CAPS_W-1:0]   caps,
		input logic                act,
		input logic [WEIGHT_W-1:0] wgt
	);
		int gap;
		gap = gaps_on ? $urandom_range(0, 3) : 0;
		@(negedge clk);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.req_type     <= rt;
		req_ch.job_id       <= id;
		req_ch.job_class    <= cls;
		req_ch.capabilities <= caps;
		req_ch.set_active   <= act;
		req_ch.set_weight   <= wgt;
		req_ch.valid        <= 1'b1;
		do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
	endtask

	// Mostly table traffic that keeps jobs active and selectable
	task automatic send_random_request();
		int                  pick;
		logic [REQ_W-1:0]    rt;
		logic [CAPS_W-1:0]   caps;
		logic                act;
		logic [WEIGHT_W-1:0] wgt;
		pick = $urandom_range(0, 99);
		caps = {$urandom, $urandom};
		act  = 1'($urandom_range(0, 1));
		wgt  = WEIGHT_W'($urandom_range(0, 255));
		if (pick < 16)
			rt = REQ_ADD;
		else if (pick < 26)
			rt = REQ_REMOVE;
		else if (pick < 60)
			rt = REQ_SELECT;
		else if (pick < 80)
			rt = REQ_UPDATE;
		else if (pick < 92)
			rt = REQ_LOOKUP;
		else if (pick < 94)
			rt = REQ_CLEAR;
		else if (pick < 97)
			rt = pick[0] ? REQ_SPARE_7 : REQ_SPARE_6;
		else
			rt = REQ_W'($urandom_range(0, 7));
		// Shape masks and updates toward eligible jobs
		if (rt == REQ_SELECT) begin
			case ($urandom_range(0, 19))
				0:             caps = CAPS_NONE;
				1, 2, 3:       caps = caps & {$urandom, $urandom};
				4, 5, 6, 7, 8,
				9, 10, 11:     caps = caps | {$urandom, $urandom};
				default:       caps = CAPS_ALL;
			endcase
		end
		if (rt == REQ_UPDATE) begin
			act = ($urandom_range(0, 4) != 0);
			case ($urandom_range(0, 9))
				0:       wgt = '0;
				1:       wgt = '1;
				default: ;
			endcase
		end
		send_request(rt, ID_W'($urandom_range(0, 15)), CLASS_W'($urandom_range(0, 63)),
			caps, act, wgt);
	endtask

	// Write the priority register once every result is back
	task automatic write_priority(input logic [PRIO_W-1:0] value);
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		cfg_wdata <= value;
		cfg_we    <= 1'b1;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	initial begin
		int                k;
		int                waited;
		int                total_fail;
		logic [PRIO_W-1:0] prio_plan [PHASES];

		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_wdata           = '0;
		gaps_on             = 1'b1;
		req_ch.valid        = 1'b0;
		req_ch.req_type     = '0;
		req_ch.job_id       = '0;
		req_ch.job_class    = '0;
		req_ch.capabilities = '0;
		req_ch.set_active   = 1'b0;
		req_ch.set_weight   = '0;
		prio_plan = '{8'd255, 8'd0, PRIO_W'($urandom_range(1, 254)), 8'd1, 8'd128,
			PRIO_W'($urandom_range(0, 255))};

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: empty table, fill to full at the reset priority
		send_request(REQ_REMOVE, 4'd0, '0, CAPS_ALL, 1'b1, 8'hff);
		for (k = 0; k < MAX_JOBS; k++)
			send_request(REQ_ADD, 4'd15, (k == 0) ? 6'd0 : (k == 1) ? 6'd63 :
				CLASS_W'($urandom_range(1, 62)), CAPS_ALL, 1'b1, 8'hff);
		send_request(REQ_ADD, 4'd0, 6'd7, CAPS_ALL, 1'b0, '0);
		// Activate the edge classes with extreme weights and select
		send_request(REQ_UPDATE, 4'd0, '0, CAPS_NONE, 1'b1, 8'hff);
		send_request(REQ_UPDATE, 4'd1, '0, CAPS_NONE, 1'b1, 8'h00);
		send_request(REQ_SELECT, 4'd0, '0, CAPS_TOP_CLASS, 1'b0, '0);
		send_request(REQ_SELECT, 4'd0, '0, CAPS_ALL, 1'b0, '0);
		send_request(REQ_SELECT, 4'd0, '0, CAPS_NONE, 1'b0, '0);
		// Hits and misses by id, reuse of the lowest free id
		send_request(REQ_LOOKUP, 4'd1, '0, CAPS_NONE, 1'b0, '0);
		send_request(REQ_REMOVE, 4'd0, '0, CAPS_NONE, 1'b0, '0);
		send_request(REQ_UPDATE, 4'd0, '0, CAPS_NONE, 1'b1, 8'h55);
		send_request(REQ_ADD, 4'd9, 6'd5, CAPS_NONE, 1'b0, '0);
		send_request(REQ_SPARE_6, 4'd3, 6'd3, CAPS_ALL, 1'b1, 8'h0f);
		send_request(REQ_SPARE_7, 4'd12, 6'd40, CAPS_ALL, 1'b0, 8'hf0);
		send_request(REQ_CLEAR, 4'd0, '0, CAPS_NONE, 1'b0, '0);
		send_request(REQ_LOOKUP, 4'd1, '0, CAPS_NONE, 1'b0, '0);

		// Random phases, one priority setting each, one phase without gaps
		for (k = 0; k < PHASES; k++) begin
			write_priority(prio_plan[k]);
			gaps_on = (k != 2);
			repeat (PHASE_ITEMS) send_random_request();
		end

		// Drain, then allow for a select still in flight
		@(negedge clk);
		req_ch.valid <= 1'b0;
		waited = 0;
		while (pending != 0 && waited < 5000) begin
			@(negedge clk);
			waited++;
		end
		repeat (40) @(negedge clk);
		total_fail = fail_count + pending;
		if (pending != 0)
			$display("%0t: %0d predicted results never arrived", $time, pending);

		$display("Checked %0d results over %0d priority settings and the reset value.",
			checked, PHASES);
		$display("Selects that picked a job: %0d, adds refused on a full table: %0d.",
			wins, fulls);
		if (total_fail == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
